/* sv/tscr_pkg.sv */
// ----------------------------------------------------------------------------
// Three-shunt current reconstruction package
// Shared types, constants and a sat16 helper for the current reconstruction
// block: payload structs, controller states and datapath command/status.
// ----------------------------------------------------------------------------
package tscr_pkg;

    localparam int ADC_BITS_DEF    = 12;
    localparam int CAL_SAMPLES_DEF = 100;
    localparam int RAW_W           = 12;
    localparam int CFG_IDX_W       = 4;
    localparam int SAT_IN_W        = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_THR = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 4'd1;

    localparam logic [15:0] SKIP_THR_RST = 16'd62259;
    localparam logic [15:0] GAIN_RST     = 16'd4096;

    localparam logic signed [16:0] ONE_THIRD_Q16     = 17'sd21845;
    localparam logic signed [16:0] INV_SQRT3_Q15     = 17'sd18919;
    localparam logic signed [16:0] TWO_INV_SQRT3_Q15 = 17'sd37837;

    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;
    localparam logic [2:0] SEC_5 = 3'd5;
    localparam logic [2:0] SEC_6 = 3'd6;

    typedef enum logic [1:0] {
        KIND_CUR      = 2'd0,
        KIND_CAL      = 2'd1,
        KIND_CAL_DONE = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAL_ACC,
        ST_DIV,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_CONV_C,
        ST_ADJ,
        ST_MEAN,
        ST_BETA_A,
        ST_BETA_B,
        ST_BETA_SUM,
        ST_OUT_CUR,
        ST_OUT_CAL,
        ST_OUT_DONE
    } t_state;

    typedef enum logic [2:0] {
        MUL_PH_A,
        MUL_PH_B,
        MUL_PH_C,
        MUL_MID,
        MUL_BETA_A,
        MUL_BETA_B
    } t_mul_sel;

    typedef struct packed {
        logic              op;
        logic [RAW_W-1:0]  raw_a;
        logic [RAW_W-1:0]  raw_b;
        logic [RAW_W-1:0]  raw_c;
        logic [15:0]       duty_a;
        logic [15:0]       duty_b;
        logic [15:0]       duty_c;
        logic [2:0]        sector;
    } t_in_item;

    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] current_a;
        logic signed [15:0] current_b;
        logic signed [15:0] current_c;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
    } t_out_item;

    typedef struct packed {
        logic     capture;
        logic     cal_acc;
        logic     div_step;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     ld_a;
        logic     ld_b;
        logic     ld_c;
        logic     adj;
        logic     mean_fix;
        logic     beta_acc;
        logic     beta_fin;
        logic     off_load;
        logic     out_load;
        t_kind    out_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic in_op;
        logic cal_last;
        logic skip;
    } t_dp_stat;

    function automatic logic signed [15:0] sat16(input logic signed [SAT_IN_W-1:0] v);
        logic signed [15:0] r;
        if (v > SAT_IN_W'(32767)) begin
            r = 16'sh7FFF;
        end else if (v < -SAT_IN_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

/* sv/three_shunt_current_reconstruct.sv */
// ----------------------------------------------------------------------------
// Three-shunt phase current reconstruction
// Usage: an input transaction carries three shunt samples, three PWM duties
// and the voltage sector, or a zero-current calibration sample. Each accepted
// transaction yields exactly one output transaction with the abc currents and
// Clarke alpha/beta, or a calibration status. Both channels use valid/stall.
// The configuration channel (valid/ready, always ready) writes the skip
// threshold at index 0 and the current gain at index 1; other indexes are
// ignored. Write it only while the block is idle.
// A conversion steps through the phase multiplies, adjust, mean removal (skipped
// when a duty exceeds the skip threshold), Clarke beta and output states,
// sequenced through one shared 19 by 17-bit multiplier.
// A calibration sample passes through accumulate and output states; the last
// of a run adds a state for the offset division, a multiplication by a
// constant reciprocal. A new input transaction is taken in the cycle after the
// previous result is loaded into the output register.
// When the receiver stalls, the result waits in the output register and the
// next item is processed up to its own result, then waits too.
// Reset restores the settings, offsets to mid scale and clears calibration.
// ----------------------------------------------------------------------------
module three_shunt_current_reconstruct
    import tscr_pkg::*;
#(
    parameter int ADC_BITS    = ADC_BITS_DEF,
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  t_in_item             i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output t_out_item            o_out_data,
    input  logic                 i_out_stall,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    logic [15:0] r_skip_thr;
    logic [15:0] r_gain;
    t_dp_cmd     dp_cmd;
    t_dp_stat    dp_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_thr <= SKIP_THR_RST;
            r_gain     <= GAIN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SKIP_THR: r_skip_thr <= i_cfg_data;
                CFG_GAIN:     r_gain     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tscr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    tscr_dp #(
        .ADC_BITS    (ADC_BITS),
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_skip_thr (r_skip_thr),
        .i_gain     (r_gain),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_out_data (o_out_data)
    );

endmodule

/* sv/tscr_dp.sv */
// ----------------------------------------------------------------------------
// Current reconstruction datapath
// Input capture, shared multiplier, phase conversion, rebuild or mean removal,
// Clarke beta, calibration accumulators with a reciprocal offset divider.
// ----------------------------------------------------------------------------
module tscr_dp
    import tscr_pkg::*;
#(
    parameter int ADC_BITS    = ADC_BITS_DEF,
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_item    i_in_data,
    input  logic [15:0] i_skip_thr,
    input  logic [15:0] i_gain,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    output t_out_item   o_out_data
);

    localparam int EFF_W = (ADC_BITS < RAW_W) ? ADC_BITS : RAW_W;
    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
    localparam int SUM_W = EFF_W + CNT_W;
    localparam int XW    = ((ADC_BITS + 2 > 18) ? ADC_BITS + 2 : 18) + 1;
    localparam int PW    = XW + 17;
    localparam logic [ADC_BITS-1:0] OFF_RST = ADC_BITS'(2048);
    localparam int     DIV_SH = SUM_W + CNT_W;
    localparam longint DIV_M  = ((longint'(1) << DIV_SH) + longint'(CAL_SAMPLES) - 1) /
                                longint'(CAL_SAMPLES);
    localparam int     DM_W   = $clog2(DIV_M + 1);
    localparam int     DP_W   = SUM_W + DM_W;
    localparam logic [DM_W-1:0] DIV_MUL = DM_W'(DIV_M);

    t_in_item                 r_in;
    t_out_item                r_out;
    logic [EFF_W-1:0]         raw_e [3];
    logic [ADC_BITS-1:0]      r_off [3];
    logic [SUM_W-1:0]         r_sum [3];
    logic [SUM_W-1:0]         n_sum [3];
    logic [SUM_W-1:0]         r_quo [3];
    logic [SUM_W-1:0]         n_quo [3];
    logic [DP_W-1:0]          dv_p  [3];
    logic [CNT_W-1:0]         r_cnt;
    logic signed [XW-1:0]     ph_d  [3];
    logic signed [XW-1:0]     mul_x;
    logic signed [16:0]       mul_y;
    logic signed [PW-1:0]     r_prod;
    logic signed [PW-1:0]     r_acc;
    logic signed [15:0]       r_a;
    logic signed [15:0]       r_b;
    logic signed [15:0]       r_c;
    logic signed [15:0]       r_beta;
    logic signed [PW:0]       cv_sum;
    logic signed [PW:0]       cv_q;
    logic signed [15:0]       cv_cur;
    logic signed [17:0]       mn_s;
    logic signed [PW:0]       mn_sum;
    logic signed [PW:0]       mn_mid;
    logic signed [PW:0]       bt_sum;
    logic signed [PW:0]       bt_q;
    logic signed [15:0]       rb_a;
    logic signed [15:0]       rb_b;
    logic signed [15:0]       rb_c;
    logic                     skip;
    logic                     cal_last;

    always_comb begin
        raw_e[0] = r_in.raw_a[EFF_W-1:0];
        raw_e[1] = r_in.raw_b[EFF_W-1:0];
        raw_e[2] = r_in.raw_c[EFF_W-1:0];
        for (int i = 0; i < 3; i++) begin
            ph_d[i]  = $signed(XW'(raw_e[i])) - $signed(XW'(r_off[i]));
            n_sum[i] = r_sum[i] + SUM_W'(raw_e[i]);
            dv_p[i]  = DP_W'(r_quo[i]) * DP_W'(DIV_MUL);
            n_quo[i] = SUM_W'(dv_p[i] >> DIV_SH);
        end
    end

    assign cal_last = (r_cnt == CNT_W'(CAL_SAMPLES - 1));
    assign skip     = (r_in.duty_a > i_skip_thr) || (r_in.duty_b > i_skip_thr) ||
                      (r_in.duty_c > i_skip_thr);
    assign mn_s     = 18'(r_a) + 18'(r_b) + 18'(r_c);

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_PH_A: begin
                mul_x = ph_d[0];
                mul_y = $signed({1'b0, i_gain});
            end
            MUL_PH_B: begin
                mul_x = ph_d[1];
                mul_y = $signed({1'b0, i_gain});
            end
            MUL_PH_C: begin
                mul_x = ph_d[2];
                mul_y = $signed({1'b0, i_gain});
            end
            MUL_MID: begin
                mul_x = XW'(mn_s);
                mul_y = ONE_THIRD_Q16;
            end
            MUL_BETA_A: begin
                mul_x = XW'(r_a);
                mul_y = INV_SQRT3_Q15;
            end
            MUL_BETA_B: begin
                mul_x = XW'(r_b);
                mul_y = TWO_INV_SQRT3_Q15;
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign cv_sum = (PW + 1)'(r_prod) + (PW + 1)'(2048);
    assign cv_q   = cv_sum >>> 12;
    assign cv_cur = sat16(SAT_IN_W'(cv_q));

    assign mn_sum = (PW + 1)'(r_prod) + (PW + 1)'(32768);
    assign mn_mid = mn_sum >>> 16;

    assign bt_sum = (PW + 1)'(r_acc) + (PW + 1)'(r_prod) + (PW + 1)'(16384);
    assign bt_q   = bt_sum >>> 15;

    assign rb_a = sat16(-SAT_IN_W'(r_b) - SAT_IN_W'(r_c));
    assign rb_b = sat16(-SAT_IN_W'(r_a) - SAT_IN_W'(r_c));
    assign rb_c = sat16(-SAT_IN_W'(r_a) - SAT_IN_W'(r_b));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_off[i] <= OFF_RST;
                r_sum[i] <= '0;
            end
            r_cnt <= '0;
        end else begin
            if (i_cmd.cal_acc) begin
                if (cal_last) begin
                    for (int i = 0; i < 3; i++) begin
                        r_sum[i] <= '0;
                    end
                    r_cnt <= '0;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        r_sum[i] <= n_sum[i];
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (i_cmd.off_load) begin
                for (int i = 0; i < 3; i++) begin
                    r_off[i] <= ADC_BITS'(r_quo[i]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_data;
        end
        if (i_cmd.cal_acc && cal_last) begin
            for (int i = 0; i < 3; i++) begin
                r_quo[i] <= n_sum[i];
            end
        end else if (i_cmd.div_step) begin
            for (int i = 0; i < 3; i++) begin
                r_quo[i] <= n_quo[i];
            end
        end
        if (i_cmd.mul_en) begin
            r_prod <= PW'(mul_x) * PW'(mul_y);
        end
        if (i_cmd.beta_acc) begin
            r_acc <= r_prod;
        end
        if (i_cmd.ld_a) begin
            r_a <= cv_cur;
        end
        if (i_cmd.ld_b) begin
            r_b <= cv_cur;
        end
        if (i_cmd.ld_c) begin
            r_c <= cv_cur;
        end
        if (i_cmd.adj && skip) begin
            case (r_in.sector) inside
                SEC_1, SEC_6: r_a <= rb_a;
                SEC_2, SEC_3: r_b <= rb_b;
                SEC_4, SEC_5: r_c <= rb_c;
                default: ;
            endcase
        end
        if (i_cmd.mean_fix) begin
            r_a <= sat16(SAT_IN_W'(r_a) - SAT_IN_W'(mn_mid));
            r_b <= sat16(SAT_IN_W'(r_b) - SAT_IN_W'(mn_mid));
            r_c <= sat16(SAT_IN_W'(r_c) - SAT_IN_W'(mn_mid));
        end
        if (i_cmd.beta_fin) begin
            r_beta <= sat16(SAT_IN_W'(bt_q));
        end
        if (i_cmd.out_load) begin
            r_out.kind <= i_cmd.out_kind;
            if (i_cmd.out_kind == KIND_CUR) begin
                r_out.current_a <= r_a;
                r_out.current_b <= r_b;
                r_out.current_c <= r_c;
                r_out.alpha     <= r_a;
                r_out.beta      <= r_beta;
            end else begin
                r_out.current_a <= '0;
                r_out.current_b <= '0;
                r_out.current_c <= '0;
                r_out.alpha     <= '0;
                r_out.beta      <= '0;
            end
        end
    end

    assign o_stat.in_op    = i_in_data.op;
    assign o_stat.cal_last = cal_last;
    assign o_stat.skip     = skip;
    assign o_out_data      = r_out;

endmodule

/* sv/tscr_ctrl.sv */
// ----------------------------------------------------------------------------
// Current reconstruction controller
// Sequences one transaction at a time through the datapath and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module tscr_ctrl
    import tscr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  logic     i_out_stall,
    output logic     o_out_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state          r_state;
    t_state          n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_go;

    assign out_go = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.mul_sel  = MUL_PH_A;
        o_cmd.out_kind = KIND_CUR;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = i_stat.in_op ? ST_CAL_ACC : ST_MUL_A;
                end
            end
            ST_CAL_ACC: begin
                o_cmd.cal_acc = 1'b1;
                if (i_stat.cal_last) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_OUT_CAL;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state        = ST_OUT_DONE;
            end
            ST_MUL_A: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_PH_A;
                n_state       = ST_MUL_B;
            end
            ST_MUL_B: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_PH_B;
                o_cmd.ld_a    = 1'b1;
                n_state       = ST_MUL_C;
            end
            ST_MUL_C: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_PH_C;
                o_cmd.ld_b    = 1'b1;
                n_state       = ST_CONV_C;
            end
            ST_CONV_C: begin
                o_cmd.ld_c = 1'b1;
                n_state    = ST_ADJ;
            end
            ST_ADJ: begin
                o_cmd.adj = 1'b1;
                if (i_stat.skip) begin
                    n_state = ST_BETA_A;
                end else begin
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.mul_sel = MUL_MID;
                    n_state       = ST_MEAN;
                end
            end
            ST_MEAN: begin
                o_cmd.mean_fix = 1'b1;
                n_state        = ST_BETA_A;
            end
            ST_BETA_A: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_BETA_A;
                n_state       = ST_BETA_B;
            end
            ST_BETA_B: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_BETA_B;
                o_cmd.beta_acc = 1'b1;
                n_state        = ST_BETA_SUM;
            end
            ST_BETA_SUM: begin
                o_cmd.beta_fin = 1'b1;
                n_state        = ST_OUT_CUR;
            end
            ST_OUT_CUR: begin
                o_cmd.out_kind = KIND_CUR;
                if (out_go) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_OUT_CAL: begin
                o_cmd.out_kind = KIND_CAL;
                if (out_go) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_OUT_DONE: begin
                o_cmd.out_kind = KIND_CAL_DONE;
                o_cmd.off_load = 1'b1;
                if (out_go) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* sim/three_shunt_current_reconstruct_tb.sv */
// ----------------------------------------------------------------------------
// Three-shunt current reconstruction testbench
// Drives shunt samples, duties and sectors into the block and checks every
// result transaction field by field against an in-bench model of the offset,
// gain, phase rebuild, mean removal, Clarke transform and calibration. A short
// table of directed vectors comes first, then random traffic with calibration
// runs, over several register settings and three idle patterns.
// ----------------------------------------------------------------------------
module three_shunt_current_reconstruct_tb
    import tscr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 258;
    localparam int TAIL_CYCLES = 40;
    localparam int CAL_RUN     = 100;

    localparam longint Q16_THIRD         = 21845;
    localparam longint Q15_INV_SQRT3     = 18919;
    localparam longint Q15_TWO_INV_SQRT3 = 37837;

    localparam logic OP_CONVERT = 1'b0;
    localparam logic OP_CAL     = 1'b1;

    localparam logic [2:0] SEC_OFF_LOW  = 3'd0;
    localparam logic [2:0] SEC_OFF_HIGH = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 4'd15;

    typedef struct {
        t_in_item  stim;
        bit        typed;
        t_out_item want;
    } t_vector;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_item             in_data   = '0;
    logic                 in_stall;
    logic                 out_valid;
    t_out_item            out_data;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data  = '0;

    logic [15:0] skip_thr;
    logic [15:0] gain_q412;
    logic [11:0] ofs_a;
    logic [11:0] ofs_b;
    logic [11:0] ofs_c;
    logic [18:0] cal_sum_a;
    logic [18:0] cal_sum_b;
    logic [18:0] cal_sum_c;
    int          cal_n;

    t_out_item   currents_q[$];
    int          field_errors = 0;
    int          quiet_cycles = 0;
    int          snd_idle     = 0;
    int          rcv_idle     = 0;
    int          items_sent   = 0;
    int          cal_items    = 0;
    int          cal_runs     = 0;
    int          rebuilds     = 0;
    int          settings     = 0;

    three_shunt_current_reconstruct dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] shunt_to_amps(input logic [11:0] raw,
                                                         input logic [11:0] ofs);
        longint p;
        p = (longint'(raw) - longint'(ofs)) * longint'(gain_q412);
        return clip16((p + 2048) >>> 12);
    endfunction

    function automatic t_out_item reconstruct_item(input t_in_item it);
        t_out_item          r;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        longint             s;
        longint             mid;
        r = '0;
        if (it.op == OP_CAL) begin
            cal_sum_a += it.raw_a;
            cal_sum_b += it.raw_b;
            cal_sum_c += it.raw_c;
            cal_n++;
            r.kind = KIND_CAL;
            if (cal_n >= CAL_RUN) begin
                ofs_a     = 12'(cal_sum_a / CAL_RUN);
                ofs_b     = 12'(cal_sum_b / CAL_RUN);
                ofs_c     = 12'(cal_sum_c / CAL_RUN);
                cal_sum_a = '0;
                cal_sum_b = '0;
                cal_sum_c = '0;
                cal_n     = 0;
                r.kind    = KIND_CAL_DONE;
                cal_runs++;
            end
            return r;
        end
        a = shunt_to_amps(it.raw_a, ofs_a);
        b = shunt_to_amps(it.raw_b, ofs_b);
        c = shunt_to_amps(it.raw_c, ofs_c);
        if (it.duty_a > skip_thr || it.duty_b > skip_thr || it.duty_c > skip_thr) begin
            case (it.sector)
                SEC_1, SEC_6: begin
                    a = clip16(-longint'(b) - longint'(c));
                    rebuilds++;
                end
                SEC_2, SEC_3: begin
                    b = clip16(-longint'(a) - longint'(c));
                    rebuilds++;
                end
                SEC_4, SEC_5: begin
                    c = clip16(-longint'(a) - longint'(b));
                    rebuilds++;
                end
                default: begin
                end
            endcase
        end else begin
            s   = longint'(a) + longint'(b) + longint'(c);
            mid = (s * Q16_THIRD + 32768) >>> 16;
            a   = clip16(longint'(a) - mid);
            b   = clip16(longint'(b) - mid);
            c   = clip16(longint'(c) - mid);
        end
        r.kind      = KIND_CUR;
        r.current_a = a;
        r.current_b = b;
        r.current_c = c;
        r.alpha     = a;
        r.beta      = clip16((longint'(a) * Q15_INV_SQRT3 +
                              longint'(b) * Q15_TWO_INV_SQRT3 + 16384) >>> 15);
        return r;
    endfunction

    function automatic t_in_item mk(input logic op, input int ra, input int rb, input int rc,
                                    input int da, input int db, input int dc,
                                    input logic [2:0] sec);
        t_in_item r;
        r.op     = op;
        r.raw_a  = 12'(ra);
        r.raw_b  = 12'(rb);
        r.raw_c  = 12'(rc);
        r.duty_a = 16'(da);
        r.duty_b = 16'(db);
        r.duty_c = 16'(dc);
        r.sector = sec;
        return r;
    endfunction

    function automatic int clamp_raw(input int v);
        if (v < 0) begin
            return 0;
        end
        if (v > 4095) begin
            return 4095;
        end
        return v;
    endfunction

    function automatic int pick_center();
        int r;
        r = $urandom_range(0, 4);
        if (r == 0) begin
            return 0;
        end
        if (r == 1) begin
            return 4095;
        end
        return $urandom_range(0, 4095);
    endfunction

    function automatic int conv_raw(input logic [11:0] ofs);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 0;
        end
        if (r == 1) begin
            return 4095;
        end
        if (r < 6) begin
            return $urandom_range(0, 4095);
        end
        return clamp_raw(int'(ofs) + int'($urandom_range(0, 128)) - 64);
    endfunction

    function automatic int pick_duty();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 0;
        end
        if (r == 1) begin
            return 65535;
        end
        if (r < 5) begin
            return $urandom_range(0, 65535);
        end
        return $urandom_range(0, int'(skip_thr));
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            field_errors++;
        end
    endtask

    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item p;
        if ($urandom_range(0, 99) < snd_idle) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < snd_idle);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        p = reconstruct_item(it);
        currents_q.push_back(typed ? want : p);
        items_sent++;
        if (it.op == OP_CAL) begin
            cal_items++;
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (currents_q.size() != 0);
    endtask

    task automatic load_settings(input logic [15:0] thr, input logic [15:0] gain,
                                 input bit stray);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SKIP_THR;
        cfg_data  <= thr;
        do @(posedge clk); while (!cfg_ready);
        skip_thr  = thr;
        cfg_index <= CFG_GAIN;
        cfg_data  <= gain;
        do @(posedge clk); while (!cfg_ready);
        gain_q412 = gain;
        if (stray) begin
            cfg_index <= CFG_UNMAPPED;
            cfg_data  <= 16'($urandom);
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        settings++;
    endtask

    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (currents_q.size() == 0) begin
                $display("%0t: result transaction with none expected, kind %0d",
                         $time, out_data.kind);
                field_errors++;
            end else begin
                want = currents_q.pop_front();
                check_field("kind", int'(want.kind), int'(out_data.kind));
                check_field("current_a", int'(want.current_a), int'(out_data.current_a));
                check_field("current_b", int'(want.current_b), int'(out_data.current_b));
                check_field("current_c", int'(want.current_c), int'(out_data.current_c));
                check_field("alpha", int'(want.alpha), int'(out_data.alpha));
                check_field("beta", int'(want.beta), int'(out_data.beta));
            end
        end
        out_stall <= ($urandom_range(0, 99) < rcv_idle);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("three_shunt_current_reconstruct verification failed");
            $finish;
        end
    end

    initial begin
        t_vector     vec[$];
        t_out_item   zero_cur;
        t_out_item   cal_ack;
        t_in_item    it;
        logic [15:0] thr_set[6];
        logic [15:0] gain_set[6];
        int          cal_left;
        int          ctr_a;
        int          ctr_b;
        int          ctr_c;
        int          sel;

        skip_thr  = SKIP_THR_RST;
        gain_q412 = GAIN_RST;
        ofs_a     = 12'd2048;
        ofs_b     = 12'd2048;
        ofs_c     = 12'd2048;
        cal_sum_a = '0;
        cal_sum_b = '0;
        cal_sum_c = '0;
        cal_n     = 0;
        zero_cur  = '0;
        cal_ack   = '0;
        cal_ack.kind = KIND_CAL;

        thr_set  = '{16'd0, 16'd65535, SKIP_THR_RST, 16'($urandom), 16'd20000, 16'd50000};
        gain_set = '{16'd65535, 16'd0, GAIN_RST, 16'($urandom), 16'd1, 16'd40000};

        vec.push_back('{mk(OP_CONVERT, 2048, 2048, 2048, 0, 0, 0, SEC_OFF_LOW), 1'b1, zero_cur});
        vec.push_back('{mk(OP_CONVERT, 0, 0, 0, 0, 0, 0, SEC_OFF_LOW), 1'b0, zero_cur});
        vec.push_back('{mk(OP_CONVERT, 4095, 4095, 4095, 0, 0, 0, SEC_1), 1'b0, zero_cur});
        vec.push_back('{mk(OP_CONVERT, 4095, 0, 2048, 0, 0, 0, SEC_3), 1'b0, zero_cur});
        vec.push_back('{mk(OP_CONVERT, 3000, 1000, 2500, SKIP_THR_RST, SKIP_THR_RST,
                           SKIP_THR_RST, SEC_1), 1'b0, zero_cur});
        vec.push_back('{mk(OP_CONVERT, 3000, 1000, 2500, SKIP_THR_RST + 1, 0, 0, SEC_1),
                        1'b0, zero_cur});
        vec.push_back('{mk(OP_CONVERT, 3000, 1000, 2500, 0, 65535, 0, SEC_2), 1'b0, zero_cur});
        vec.push_back('{mk(OP_CONVERT, 3000, 1000, 2500, 0, 0, 65535, SEC_3), 1'b0, zero_cur});
        vec.push_back('{mk(OP_CONVERT, 3000, 1000, 2500, 65535, 65535, 65535, SEC_4),
                        1'b0, zero_cur});
        vec.push_back('{mk(OP_CONVERT, 3000, 1000, 2500, 65535, 0, 0, SEC_5), 1'b0, zero_cur});
        vec.push_back('{mk(OP_CONVERT, 3000, 1000, 2500, 0, 65535, 0, SEC_6), 1'b0, zero_cur});
        vec.push_back('{mk(OP_CONVERT, 3000, 1000, 2500, 65535, 0, 0, SEC_OFF_LOW),
                        1'b0, zero_cur});
        vec.push_back('{mk(OP_CONVERT, 3000, 1000, 2500, 0, 0, 65535, SEC_OFF_HIGH),
                        1'b0, zero_cur});
        vec.push_back('{mk(OP_CAL, 0, 0, 0, 0, 0, 0, SEC_OFF_LOW), 1'b1, cal_ack});
        vec.push_back('{mk(OP_CAL, 4095, 4095, 4095, 65535, 65535, 65535, SEC_OFF_HIGH),
                        1'b1, cal_ack});
        vec.push_back('{mk(OP_CONVERT, 4095, 0, 4095, 65535, 65535, 65535, SEC_6),
                        1'b0, zero_cur});
        vec.push_back('{mk(OP_CONVERT, 0, 4095, 0, 0, 0, 0, SEC_5), 1'b0, zero_cur});
        vec.push_back('{mk(OP_CONVERT, 0, 4095, 4095, 65535, 0, 0, SEC_4), 1'b0, zero_cur});
        vec.push_back('{mk(OP_CONVERT, 4095, 4095, 0, 0, 65535, 0, SEC_2), 1'b0, zero_cur});
        vec.push_back('{mk(OP_CAL, 2730, 1365, 3003, 40000, 100, 7, SEC_3), 1'b1, cal_ack});

        snd_idle = 35;
        rcv_idle = 83;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (vec[i]) begin
            send_item(vec[i].stim, vec[i].typed, vec[i].want);
        end

        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            snd_idle = (ph < 2) ? 35 : ((ph < 4) ? 83 : 0);
            rcv_idle = (ph < 2) ? 83 : ((ph < 4) ? 35 : 0);
            load_settings(thr_set[ph], gain_set[ph], ph == 2);
            cal_left = (ph == 0) ? CAL_RUN : 0;
            ctr_a = pick_center();
            ctr_b = pick_center();
            ctr_c = pick_center();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 2) begin
                    wait_drained();
                end
                if (cal_left == 0 && $urandom_range(0, 99) < 4) begin
                    cal_left = CAL_RUN;
                    ctr_a = pick_center();
                    ctr_b = pick_center();
                    ctr_c = pick_center();
                end
                sel = $urandom_range(0, 99);
                if (cal_left > 0 && sel < 85) begin
                    it = mk(OP_CAL,
                            clamp_raw(ctr_a + int'($urandom_range(0, 80)) - 40),
                            clamp_raw(ctr_b + int'($urandom_range(0, 80)) - 40),
                            clamp_raw(ctr_c + int'($urandom_range(0, 80)) - 40),
                            $urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 65535), 3'($urandom_range(0, 7)));
                    cal_left--;
                end else if (sel > 96) begin
                    it = mk(OP_CAL, $urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(0, 4095), $urandom_range(0, 65535),
                            $urandom_range(0, 65535), $urandom_range(0, 65535),
                            3'($urandom_range(0, 7)));
                end else begin
                    it = mk(OP_CONVERT, conv_raw(ofs_a), conv_raw(ofs_b), conv_raw(ofs_c),
                            pick_duty(), pick_duty(), pick_duty(), 3'($urandom_range(0, 7)));
                end
                send_item(it, 1'b0, zero_cur);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d input transactions, %0d calibration samples and %0d",
                 items_sent, cal_items, cal_runs);
        $display("completed calibration runs, %0d phase rebuilds, %0d register settings.",
                 rebuilds, settings);
        if (field_errors == 0) begin
            $display("three_shunt_current_reconstruct verification clean");
        end else begin
            $display("three_shunt_current_reconstruct verification failed");
        end
        $finish;
    end

endmodule

/* three_shunt_current_reconstruct.f */
sv/tscr_pkg.sv
sv/tscr_dp.sv
sv/tscr_ctrl.sv
sv/three_shunt_current_reconstruct.sv
sim/three_shunt_current_reconstruct_tb.sv
